### hw/rtl/hdt_pkg.sv
// Package for the hashed directory table: slot and beat types, codes,
// hash constants and the integrity fold. No dependencies.
`default_nettype none
package hdt_pkg;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_UPSERT = 2'd1;
    localparam logic [1:0] ACT_ERASE  = 2'd2;
    localparam logic [1:0] ACT_RSVD   = 2'd3;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_NOT_FOUND = 3'd1;
    localparam logic [2:0] STS_INVALID   = 3'd2;
    localparam logic [2:0] STS_STALE     = 3'd3;
    localparam logic [2:0] STS_FULL      = 3'd4;
    localparam logic [2:0] STS_ABSENT    = 3'd5;

    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_LIVE  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    localparam logic [1:0] MESI_I = 2'd0;
    localparam logic [1:0] MESI_S = 2'd1;
    localparam logic [1:0] MESI_E = 2'd2;
    localparam logic [1:0] MESI_M = 2'd3;

    localparam logic [1:0] CFG_GROUP_COUNT  = 2'd0;
    localparam logic [1:0] CFG_BUCKET_COUNT = 2'd1;
    localparam logic [1:0] CFG_HASH_SEED    = 2'd2;

    localparam logic [4:0]  GROUP_COUNT_RST  = 5'd16;
    localparam logic [6:0]  BUCKET_COUNT_RST = 7'd64;

    localparam logic [63:0] MIX_C1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2   = 64'h94d049bb133111eb;
    localparam logic [63:0] SEED_XOR = 64'h0123456789ABCDEF;
    localparam logic [3:0]  NIBBLE_MASK = 4'hF;
    localparam logic [23:0] EPOCH_MASK  = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [43:0] line_address;
        logic [1:0]  coherence_state;
        logic [15:0] sharer_mask;
        logic [23:0] epoch;
    } hdt_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  result_state;
        logic [15:0] result_sharers;
        logic [23:0] result_epoch;
        logic [7:0]  result_check;
    } hdt_rsp_t;

    typedef struct packed {
        logic [43:0] addr;
        logic [1:0]  st;
        logic [1:0]  mesi;
        logic [15:0] sharers;
        logic [23:0] epoch;
        logic [7:0]  check;
    } hdt_slot_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MIX_G, S_MOD_G, S_MIX_B, S_MOD_B,
        S_READ, S_CHECK, S_FINISH
    } hdt_state_t;

    function automatic logic [7:0] fold(input logic [43:0] a, input logic [1:0] st,
                                        input logic [1:0] mesi, input logic [15:0] sh,
                                        input logic [23:0] ep);
        logic [7:0] c;
        c = a[7:0] ^ a[15:8] ^ a[23:16] ^ a[31:24] ^ a[39:32];
        c = c ^ {4'b0, a[43:40] & NIBBLE_MASK};
        c = c ^ {4'b0, mesi, st};
        c = c ^ sh[7:0] ^ sh[15:8];
        c = c ^ ep[7:0] ^ ep[15:8] ^ ep[23:16];
        return c;
    endfunction

    function automatic hdt_slot_t make_slot(input logic [43:0] a, input logic [1:0] st,
                                            input logic [1:0] mesi, input logic [15:0] sh,
                                            input logic [23:0] ep);
        hdt_slot_t s;
        s.addr    = a;
        s.st      = st;
        s.mesi    = mesi;
        s.sharers = sh;
        s.epoch   = ep & EPOCH_MASK;
        s.check   = fold(a, st, mesi, sh, ep & EPOCH_MASK);
        return s;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/hdt_slot_ram.sv
// Slot store: one write port, one registered read port.
// Depends on hdt_pkg for the slot type.
`default_nettype none
module hdt_slot_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire hdt_pkg::hdt_slot_t wdata,
    input  wire logic [AW-1:0]     raddr,
    output hdt_pkg::hdt_slot_t     rdata
);
    hdt_pkg::hdt_slot_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/hdt_mix.sv
// Seeded splitmix64 finalizer on one shared 32x32 multiplier.
// Depends on hdt_pkg for the mix constants.
`default_nettype none
module hdt_mix (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] x_in,
    input  wire logic [63:0] seed_in,
    output logic             done,
    output logic [63:0]      hash_out
);
    logic        busy_reg, sel_reg, done_reg;
    logic [1:0]  ph_reg;
    logic [63:0] op_reg, prod_reg, acc_reg, hash_reg;
    logic [63:0] x0, cst, acc_plus, prod_next;
    logic [31:0] ma, mb;

    always_comb begin
        x0        = x_in + seed_in;
        cst       = sel_reg ? hdt_pkg::MIX_C2 : hdt_pkg::MIX_C1;
        ma        = (ph_reg == 2'd2) ? op_reg[63:32] : op_reg[31:0];
        mb        = (ph_reg == 2'd1) ? cst[63:32] : cst[31:0];
        prod_next = {32'b0, ma} * {32'b0, mb};
        acc_plus  = acc_reg + {prod_reg[31:0], 32'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sel_reg  <= 1'b0;
            ph_reg   <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                sel_reg  <= 1'b0;
                ph_reg   <= 2'd0;
            end else if (busy_reg) begin
                ph_reg <= ph_reg + 2'd1;
                if (ph_reg == 2'd3) begin
                    if (sel_reg) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    sel_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg <= x0 ^ (x0 >> 30);
        end else if (busy_reg) begin
            prod_reg <= prod_next;
            case (ph_reg)
                2'd1: acc_reg <= prod_reg;
                2'd2: acc_reg <= acc_plus;
                2'd3: begin
                    if (sel_reg) hash_reg <= acc_plus ^ (acc_plus >> 31);
                    else op_reg <= acc_plus ^ (acc_plus >> 27);
                end
                default: ;
            endcase
        end
    end

    assign done     = done_reg;
    assign hash_out = hash_reg;
endmodule
`default_nettype wire

### hw/rtl/hdt_mod.sv
// 64-bit by 7-bit remainder, four dividend bits a cycle.
// Standalone; no package use.
`default_nettype none
module hdt_mod (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [6:0]  divisor,
    output logic             done,
    output logic [6:0]       rem
);
    localparam int STEP = 4;

    logic        busy_reg, done_reg;
    logic [3:0]  cnt_reg;
    logic [63:0] dvd_reg;
    logic [6:0]  dsr_reg, rem_reg;
    logic [7:0]  r;

    always_comb begin
        r = {1'b0, rem_reg};
        for (int i = 0; i < STEP; i++) begin
            r = {r[6:0], dvd_reg[63-i]};
            if (r >= {1'b0, dsr_reg}) r = r - {1'b0, dsr_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= 7'd0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << STEP;
            rem_reg <= r[6:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;
endmodule
`default_nettype wire

### hw/rtl/hashed_directory_table.sv
// Hashed coherence directory top level: request sequencer, probe walk and
// result register. Depends on hdt_pkg, hdt_mix, hdt_mod and hdt_slot_ram.
//
//   port group | dir | handshake       | payload
//   s_*        | in  | s_valid/s_ready | s_data  (hdt_req_t)
//   m_*        | out | m_valid/m_ready | m_data  (hdt_rsp_t)
//   cfg_*      | in  | cfg_we          | cfg_index, cfg_wdata
//
// One request at a time. A request is accepted, then hashed twice (group,
// then home bucket), each time with 8 multiplier steps and 16 remainder
// steps on the shared units; then each slot probed goes through a read
// state and a check state on the one read port, and a finish step ends it.
// Malformed requests skip straight from acceptance to the finish step.
// After reset a clearing pass writes every slot empty, one slot a cycle
// (MAX_GROUPS*MAX_BUCKETS*SLOTS_PER_BUCKET slots, 4096 by default),
// s_ready low meanwhile. A result waiting in the output register never
// blocks acceptance; only the finish step of the next request holds.
`default_nettype none
module hashed_directory_table #(
    parameter int MAX_GROUPS       = 16,
    parameter int MAX_BUCKETS      = 64,
    parameter int SLOTS_PER_BUCKET = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire hdt_pkg::hdt_req_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output hdt_pkg::hdt_rsp_t      m_data,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [63:0]       cfg_wdata
);
    localparam int SLOT_TOTAL = MAX_GROUPS * MAX_BUCKETS * SLOTS_PER_BUCKET;
    localparam int IW = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
    localparam int SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam logic [6:0] MAXG7 = 7'((MAX_GROUPS > 127) ? 127 : MAX_GROUPS);
    localparam logic [6:0] MAXB7 = 7'((MAX_BUCKETS > 127) ? 127 : MAX_BUCKETS);

    // configuration
    logic [4:0]  group_count_reg;
    logic [6:0]  bucket_count_reg;
    logic [63:0] hash_seed_reg;
    logic [6:0]  groups_eff, buckets_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_count_reg  <= hdt_pkg::GROUP_COUNT_RST;
            bucket_count_reg <= hdt_pkg::BUCKET_COUNT_RST;
            hash_seed_reg    <= 64'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                hdt_pkg::CFG_GROUP_COUNT:  group_count_reg  <= cfg_wdata[4:0];
                hdt_pkg::CFG_BUCKET_COUNT: bucket_count_reg <= cfg_wdata[6:0];
                hdt_pkg::CFG_HASH_SEED:    hash_seed_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamp the counts: zero acts as one, above the maximum acts as the maximum
    always_comb begin
        if (group_count_reg == 5'd0) groups_eff = 7'd1;
        else if (32'(group_count_reg) > MAX_GROUPS) groups_eff = MAXG7;
        else groups_eff = {2'b0, group_count_reg};
        if (bucket_count_reg == 7'd0) buckets_eff = 7'd1;
        else if (32'(bucket_count_reg) > MAX_BUCKETS) buckets_eff = MAXB7;
        else buckets_eff = bucket_count_reg;
    end

    // state and request context
    hdt_pkg::hdt_state_t state_reg, state_next;
    hdt_pkg::hdt_req_t   req_reg;
    hdt_pkg::hdt_slot_t  hit_reg;
    logic          bad_reg, hit_f_reg, emp_f_reg, tomb_f_reg;
    logic [IW-1:0] hit_idx_reg, emp_idx_reg, tomb_idx_reg, clr_reg;
    logic [6:0]    g_reg, b_reg, off_reg;
    logic [SW-1:0] s_reg;
    logic          m_valid_reg;
    hdt_pkg::hdt_rsp_t m_data_reg;

    // submodule wiring
    logic        mix_start, mix_done, mod_start, mod_done;
    logic [63:0] mix_x, mix_seed, mix_hash;
    logic [6:0]  mod_div, mod_rem;
    logic          mem_we;
    logic [IW-1:0] mem_waddr, cur_idx;
    hdt_pkg::hdt_slot_t mem_wdata, rd;

    hdt_mix u_mix (
        .aclk(aclk), .aresetn(aresetn), .start(mix_start), .x_in(mix_x),
        .seed_in(mix_seed), .done(mix_done), .hash_out(mix_hash)
    );

    hdt_mod u_mod (
        .aclk(aclk), .aresetn(aresetn), .start(mod_start), .dividend(mix_hash),
        .divisor(mod_div), .done(mod_done), .rem(mod_rem)
    );

    hdt_slot_ram #(.DEPTH(SLOT_TOTAL), .AW(IW)) u_ram (
        .aclk(aclk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(cur_idx), .rdata(rd)
    );

    // request screening at the accept beat
    logic       s_fire, s_bad, sh_onehot, sh_ok;
    always_comb begin
        sh_onehot = (s_data.sharer_mask != 16'd0) &&
                    ((s_data.sharer_mask & (s_data.sharer_mask - 16'd1)) == 16'd0);
        case (s_data.coherence_state)
            hdt_pkg::MESI_I: sh_ok = (s_data.sharer_mask == 16'd0);
            hdt_pkg::MESI_S: sh_ok = 1'b1;
            default:         sh_ok = sh_onehot;
        endcase
        s_bad = (s_data.action == hdt_pkg::ACT_RSVD) ||
                (s_data.line_address[5:0] != 6'd0) ||
                ((s_data.action == hdt_pkg::ACT_UPSERT) && !sh_ok);
    end

    assign s_ready = (state_reg == hdt_pkg::S_IDLE);
    assign s_fire  = s_valid && s_ready;

    // slot address of the current probe position
    assign cur_idx = IW'((IW'(g_reg) * IW'(MAX_BUCKETS) + IW'(b_reg)) * IW'(SLOTS_PER_BUCKET)
                         + IW'(s_reg));

    // probe decisions on the slot just read
    logic rd_hit, rd_emp, rd_tomb, emp_any, last_slot, last_bucket;
    assign rd_hit      = (rd.st == hdt_pkg::SLOT_LIVE) && (rd.addr == req_reg.line_address);
    assign rd_emp      = (rd.st == hdt_pkg::SLOT_EMPTY);
    assign rd_tomb     = (rd.st == hdt_pkg::SLOT_TOMB);
    assign emp_any     = emp_f_reg || rd_emp;
    assign last_slot   = (s_reg == SW'(SLOTS_PER_BUCKET - 1));
    assign last_bucket = ((off_reg + 7'd1) == buckets_eff);

    // finish step: result and write-back
    logic fin_go;
    hdt_pkg::hdt_rsp_t rsp;
    logic fin_we;
    logic [IW-1:0] fin_addr;
    hdt_pkg::hdt_slot_t fin_data;

    assign fin_go = (state_reg == hdt_pkg::S_FINISH) && (!m_valid_reg || m_ready);

    always_comb begin
        rsp      = '0;
        fin_we   = 1'b0;
        fin_addr = hit_idx_reg;
        fin_data = hdt_pkg::make_slot(req_reg.line_address, hdt_pkg::SLOT_LIVE,
                                      req_reg.coherence_state, req_reg.sharer_mask,
                                      req_reg.epoch);
        if (bad_reg) begin
            rsp.status = hdt_pkg::STS_INVALID;
        end else begin
            case (req_reg.action)
                hdt_pkg::ACT_LOOKUP: begin
                    if (hit_f_reg) begin
                        rsp.status         = hdt_pkg::STS_OK;
                        rsp.result_state   = hit_reg.mesi;
                        rsp.result_sharers = hit_reg.sharers;
                        rsp.result_epoch   = hit_reg.epoch;
                        rsp.result_check   = hit_reg.check;
                    end else begin
                        rsp.status = emp_f_reg ? hdt_pkg::STS_NOT_FOUND : hdt_pkg::STS_FULL;
                    end
                end
                hdt_pkg::ACT_UPSERT: begin
                    if (hit_f_reg) begin
                        if (req_reg.epoch < hit_reg.epoch) begin
                            rsp.status = hdt_pkg::STS_STALE;
                        end else begin
                            rsp.status = hdt_pkg::STS_OK;
                            fin_we     = 1'b1;
                        end
                    end else if (tomb_f_reg) begin
                        rsp.status = hdt_pkg::STS_OK;
                        fin_we     = 1'b1;
                        fin_addr   = tomb_idx_reg;
                    end else if (emp_f_reg) begin
                        rsp.status = hdt_pkg::STS_OK;
                        fin_we     = 1'b1;
                        fin_addr   = emp_idx_reg;
                    end else begin
                        rsp.status = hdt_pkg::STS_FULL;
                    end
                end
                hdt_pkg::ACT_ERASE: begin
                    fin_data = hdt_pkg::make_slot(hit_reg.addr, hdt_pkg::SLOT_TOMB,
                                                  hit_reg.mesi, hit_reg.sharers,
                                                  hit_reg.epoch);
                    if (!hit_f_reg) begin
                        rsp.status = emp_f_reg ? hdt_pkg::STS_ABSENT : hdt_pkg::STS_FULL;
                    end else if (req_reg.epoch < hit_reg.epoch) begin
                        rsp.status = hdt_pkg::STS_STALE;
                    end else begin
                        rsp.status = hdt_pkg::STS_OK;
                        fin_we     = 1'b1;
                    end
                end
                default: rsp.status = hdt_pkg::STS_INVALID;
            endcase
        end
    end

    // next state and strobes
    always_comb begin
        state_next = state_reg;
        mix_start  = 1'b0;
        mix_x      = {26'b0, req_reg.line_address[43:6]};
        mix_seed   = hash_seed_reg ^ hdt_pkg::SEED_XOR;
        mod_start  = 1'b0;
        mod_div    = buckets_eff;
        mem_we     = 1'b0;
        mem_waddr  = fin_addr;
        mem_wdata  = fin_data;
        case (state_reg)
            hdt_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == IW'(SLOT_TOTAL - 1)) state_next = hdt_pkg::S_IDLE;
            end
            hdt_pkg::S_IDLE: begin
                // hash the group from the live beat rather than the registered request
                mix_x    = {26'b0, s_data.line_address[43:6]};
                mix_seed = hash_seed_reg;
                if (s_fire) begin
                    if (s_bad) begin
                        state_next = hdt_pkg::S_FINISH;
                    end else begin
                        mix_start  = 1'b1;
                        state_next = hdt_pkg::S_MIX_G;
                    end
                end
            end
            hdt_pkg::S_MIX_G: begin
                mod_div = groups_eff;
                if (mix_done) begin
                    mod_start  = 1'b1;
                    state_next = hdt_pkg::S_MOD_G;
                end
            end
            hdt_pkg::S_MOD_G: begin
                if (mod_done) begin
                    mix_start  = 1'b1;
                    state_next = hdt_pkg::S_MIX_B;
                end
            end
            hdt_pkg::S_MIX_B: begin
                if (mix_done) begin
                    mod_start  = 1'b1;
                    state_next = hdt_pkg::S_MOD_B;
                end
            end
            hdt_pkg::S_MOD_B: begin
                if (mod_done) state_next = hdt_pkg::S_READ;
            end
            hdt_pkg::S_READ: begin
                state_next = hdt_pkg::S_CHECK;
            end
            hdt_pkg::S_CHECK: begin
                // stop at a hit, after the bucket that held an empty slot, or after the last bucket
                if (rd_hit) state_next = hdt_pkg::S_FINISH;
                else if (last_slot && (emp_any || last_bucket)) state_next = hdt_pkg::S_FINISH;
                else state_next = hdt_pkg::S_READ;
            end
            hdt_pkg::S_FINISH: begin
                if (fin_go) begin
                    mem_we     = fin_we;
                    state_next = hdt_pkg::S_IDLE;
                end
            end
            default: state_next = hdt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hdt_pkg::S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == hdt_pkg::S_CLEAR) clr_reg <= clr_reg + IW'(1);
            if (fin_go) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // datapath context
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg    <= s_data;
            bad_reg    <= s_bad;
            hit_f_reg  <= 1'b0;
            emp_f_reg  <= 1'b0;
            tomb_f_reg <= 1'b0;
        end
        if (state_reg == hdt_pkg::S_MOD_G && mod_done) g_reg <= mod_rem;
        if (state_reg == hdt_pkg::S_MOD_B && mod_done) begin
            b_reg   <= mod_rem;
            s_reg   <= '0;
            off_reg <= 7'd0;
        end
        if (state_reg == hdt_pkg::S_CHECK) begin
            if (rd_hit) begin
                hit_f_reg   <= 1'b1;
                hit_idx_reg <= cur_idx;
                hit_reg     <= rd;
            end else begin
                if (rd_emp && !emp_f_reg) begin
                    emp_f_reg   <= 1'b1;
                    emp_idx_reg <= cur_idx;
                end
                if (rd_tomb && !tomb_f_reg) begin
                    tomb_f_reg   <= 1'b1;
                    tomb_idx_reg <= cur_idx;
                end
                // advance slot, then bucket with wrap-around
                if (last_slot) begin
                    s_reg   <= '0;
                    off_reg <= off_reg + 7'd1;
                    b_reg   <= ((b_reg + 7'd1) == buckets_eff) ? 7'd0 : b_reg + 7'd1;
                end else begin
                    s_reg <= s_reg + SW'(1);
                end
            end
        end
        if (fin_go) m_data_reg <= rsp;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // the probe never walks past the bucket limit
    a_probe_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hdt_pkg::S_CHECK) |-> (off_reg < buckets_eff))
        else $error("probe offset beyond bucket count");

    // the store is written only by the clearing pass or a finish step
    a_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == hdt_pkg::S_CLEAR || state_reg == hdt_pkg::S_FINISH))
        else $error("slot write outside clear or finish");

    // a new result only appears after a finish step
    a_rsp_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == hdt_pkg::S_FINISH))
        else $error("result without finish step");

    // the mix unit reports completion only in its own wait states
    a_mix_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mix_done |-> (state_reg == hdt_pkg::S_MIX_G || state_reg == hdt_pkg::S_MIX_B))
        else $error("hash done outside wait state");
endmodule
`default_nettype wire
